// File: hw/rtl/thpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package thpc_pkg;

  // Command codes carried in the input transaction
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_STOP   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_ON_TIME   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_OFF_TIME  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ON_TIME   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DOWN_TIME = 3'd4;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TEMP_W     = 16;

  typedef struct packed {
    logic                     cmd;
    logic [TIME_W-1:0]        now_ms;
    logic signed [TEMP_W-1:0] temperature;
  } in_t;

  typedef struct packed {
    logic heater_drive;
    logic heating_on;
  } out_t;

endpackage

`default_nettype wire

// File: hw/rtl/thermostat_heater_pulse_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Bang-bang heater thermostat with minimum on/off lockout times and a pulsed
// drive pin. Each input transaction (update or stop command, millisecond time,
// signed temperature) produces exactly one output transaction carrying the pin
// level and the heating flag after that step. Throughput is one transaction
// per clock unless out_ready stalls the output; a transaction goes from the
// input register through the update logic into the output register. The
// thermostat state is written in the same cycle the result is registered, so
// consecutive transactions see each other's effect with no bubble. All
// elapsed times are 32-bit wrapping differences against stored timestamps.
// Configuration registers (setpoint, min_on_time, min_off_time, max_on_time,
// min_down_time) reset to zero; the user must write them via cfg_we/cfg_index/
// cfg_data only while idle (not enforced); an index past the last is ignored.
module thermostat_heater_pulse_controller (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire thpc_pkg::in_t                       in_data,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      thpc_pkg::out_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [thpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [thpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers
  logic signed [thpc_pkg::TEMP_W-1:0] setpoint;
  logic [thpc_pkg::TIME_W-1:0]        min_on_time;
  logic [thpc_pkg::TIME_W-1:0]        min_off_time;
  logic [thpc_pkg::TIME_W-1:0]        max_on_time;
  logic [thpc_pkg::TIME_W-1:0]        min_down_time;

  // Thermostat state
  logic                        heating;
  logic                        pulse_up;
  logic                        pin_level;
  logic [thpc_pkg::TIME_W-1:0] last_on_ms;
  logic [thpc_pkg::TIME_W-1:0] last_off_ms;
  logic [thpc_pkg::TIME_W-1:0] last_pulse_ms;

  logic                        heating_next;
  logic                        pulse_up_next;
  logic                        pin_level_next;
  logic [thpc_pkg::TIME_W-1:0] last_on_ms_next;
  logic [thpc_pkg::TIME_W-1:0] last_off_ms_next;
  logic [thpc_pkg::TIME_W-1:0] last_pulse_ms_next;

  // Input register stage
  logic          s1_valid;
  thpc_pkg::in_t s1_data;

  // Step the thermostat when a transaction sits in the input register and the
  // output register is free or being drained this cycle.
  logic advance;
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint      <= '0;
      min_on_time   <= '0;
      min_off_time  <= '0;
      max_on_time   <= '0;
      min_down_time <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        thpc_pkg::REG_SETPOINT:      setpoint      <= cfg_data[thpc_pkg::TEMP_W-1:0];
        thpc_pkg::REG_MIN_ON_TIME:   min_on_time   <= cfg_data;
        thpc_pkg::REG_MIN_OFF_TIME:  min_off_time  <= cfg_data;
        thpc_pkg::REG_MAX_ON_TIME:   max_on_time   <= cfg_data;
        thpc_pkg::REG_MIN_DOWN_TIME: min_down_time <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Load the input register; hold it while the step is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Elapsed times since the stored timestamps, modulo 2^32
  logic [thpc_pkg::TIME_W-1:0] since_on;
  logic [thpc_pkg::TIME_W-1:0] since_off;
  logic [thpc_pkg::TIME_W-1:0] since_pulse;
  logic                        locked;
  logic                        want_heat;

  assign since_on    = s1_data.now_ms - last_on_ms;
  assign since_off   = s1_data.now_ms - last_off_ms;
  assign since_pulse = s1_data.now_ms - last_pulse_ms;

  // Lockout: keep the current state until the minimum on or off time is over.
  assign locked    = heating ? (since_on < min_on_time) : (since_off < min_off_time);
  assign want_heat = s1_data.temperature < setpoint;

  always_comb begin
    heating_next       = heating;
    pulse_up_next      = pulse_up;
    pin_level_next     = pin_level;
    last_on_ms_next    = last_on_ms;
    last_off_ms_next   = last_off_ms;
    last_pulse_ms_next = last_pulse_ms;

    if (s1_data.cmd == thpc_pkg::CMD_STOP) begin
      // Stop: force the pin low and clear heating; pulse phase and lockout
      // timestamps are kept.
      pin_level_next = 1'b0;
      heating_next   = 1'b0;
    end else if (!locked) begin
      if (want_heat) begin
        if (!heating) begin
          last_on_ms_next = s1_data.now_ms;
        end
        heating_next = 1'b1;
        // Pulse the pin: drop after the up period, rise after the down period.
        if (pulse_up && (since_pulse > max_on_time)) begin
          pin_level_next     = 1'b0;
          pulse_up_next      = 1'b0;
          last_pulse_ms_next = s1_data.now_ms;
        end else if (!pulse_up && (since_pulse > min_down_time)) begin
          pin_level_next     = 1'b1;
          pulse_up_next      = 1'b1;
          last_pulse_ms_next = s1_data.now_ms;
        end
      end else begin
        if (heating) begin
          last_off_ms_next = s1_data.now_ms;
        end
        pin_level_next = 1'b0;
        heating_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heating       <= 1'b0;
      pulse_up      <= 1'b0;
      pin_level     <= 1'b0;
      last_on_ms    <= '0;
      last_off_ms   <= '0;
      last_pulse_ms <= '0;
    end else if (advance) begin
      heating       <= heating_next;
      pulse_up      <= pulse_up_next;
      pin_level     <= pin_level_next;
      last_on_ms    <= last_on_ms_next;
      last_off_ms   <= last_off_ms_next;
      last_pulse_ms <= last_pulse_ms_next;
    end
  end

  // Output register: present one result per transaction; hold it until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.heater_drive <= pin_level_next;
      out_data.heating_on   <= heating_next;
    end
  end

endmodule

`default_nettype wire
